// ===== rtl/lmcr_pkg.sv =====
`default_nettype none

package lmcr_pkg;

   // default sizes of the driver chain
   localparam int DRIVERS_PER_COMMAND_DEF = 4;
   localparam int ROWS_DEF                = 8;

   // frame buffer geometry
   localparam int FB_DEPTH = 64;
   localparam int FB_IDX_W = 6;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // request codes on req_type
   localparam logic [2:0] REQ_WRITE     = 3'd0;
   localparam logic [2:0] REQ_REFRESH   = 3'd1;
   localparam logic [2:0] REQ_COMMAND   = 3'd2;
   localparam logic [2:0] REQ_INTENSITY = 3'd3;
   localparam logic [2:0] REQ_CLEAR     = 3'd4;
   localparam logic [2:0] REQ_INIT      = 3'd5;

   // driver register addresses
   localparam logic [7:0] REG_DECODE       = 8'h09;
   localparam logic [7:0] REG_INTENSITY    = 8'h0A;
   localparam logic [7:0] REG_SCAN_LIMIT   = 8'h0B;
   localparam logic [7:0] REG_SHUTDOWN     = 8'h0C;
   localparam logic [7:0] REG_DISPLAY_TEST = 8'h0F;

   // set-up data values and limits
   localparam logic [7:0] DATA_ZERO       = 8'h00;
   localparam logic [7:0] DATA_SCAN_ALL   = 8'h07;
   localparam logic [7:0] DATA_NORMAL_OP  = 8'h01;
   localparam logic [7:0] INTENSITY_LIMIT = 8'd15;

   // select masks
   localparam logic [1:0] SEL_FIRST = 2'b01;
   localparam logic [1:0] SEL_BOTH  = 2'b11;

   // classified command kinds
   typedef enum logic [2:0] {
      KIND_WRITE,
      KIND_REFRESH,
      KIND_COMMAND,
      KIND_CLEAR,
      KIND_INIT
   } kind_type;

   // one queued command
   typedef struct packed {
      kind_type              kind;
      logic [FB_IDX_W-1:0]   index;
      logic [7:0]            addr;
      logic [7:0]            data;
   } cmd_type;

   // back-end sequence phase
   typedef enum logic [3:0] {
      PH_IDLE,
      PH_DECODE,
      PH_INTENSITY,
      PH_SCAN,
      PH_SHUTDOWN,
      PH_TEST,
      PH_CLEAR,
      PH_COMMAND,
      PH_REFRESH
   } phase_type;

endpackage

`default_nettype wire

// ===== rtl/led_matrix_chain_refresher.sv =====
// LED matrix chain refresher: frame buffer plus word sequencer for a serial driver chain.
// Request channel (req_*): valid/stall. Each request is a buffer write, refresh, command-all,
// intensity, clear or init; unknown codes are taken and dropped without results.
// Response channel (rsp_*): one 16-bit word per transfer (address byte, data byte) with its
// select mask, a frame_end flag for the chip-select rise and run_last on a request's last word.
// A request passes through a two-entry command queue; the sequencer pops one command per
// start cycle, then emits one word per cycle while rsp_stall does not hold the output. With
// an idle sequencer the first word passes the queue, sequencer state, read stage and output
// register. A refresh gives 64 words, a clear ROWS*DRIVERS_PER_COMMAND words, an init up
// to 64 words; a buffer write emits none. The rate is set by the single sequencer producing
// words through the single-read-port frame buffer. Runs longer than 64 words are cut at the 64th.
// Reset empties the queue and the pipeline and marks the whole frame buffer as zero.
// When the receiver stalls, the output word holds, the sequencer pauses, the queue fills
// and req_stall rises once the queue is full.
`default_nettype none

module led_matrix_chain_refresher #(
   parameter int DRIVERS_PER_COMMAND = lmcr_pkg::DRIVERS_PER_COMMAND_DEF,
   parameter int ROWS                = lmcr_pkg::ROWS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [2:0]                    req_type,
   input  wire logic [lmcr_pkg::FB_IDX_W-1:0] req_buffer_index,
   input  wire logic [3:0]                    req_reg_address,
   input  wire logic [7:0]                    req_value,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [15:0]                        rsp_wire_word,
   output logic [1:0]                         rsp_select_mask,
   output logic                               rsp_frame_end,
   output logic                               rsp_run_last
);

   logic              q_full, push, pop, head_valid;
   lmcr_pkg::cmd_type push_cmd, head_cmd;

   // request classification
   lmcr_front u_front (
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_buffer_index (req_buffer_index),
      .req_reg_address  (req_reg_address),
      .req_value        (req_value),
      .q_full           (q_full),
      .push             (push),
      .push_cmd         (push_cmd)
   );

   // command queue
   lmcr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   // word sequencer and frame buffer
   lmcr_back #(
      .DRIVERS_PER_COMMAND (DRIVERS_PER_COMMAND),
      .ROWS                (ROWS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_cmd        (head_cmd),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_wire_word   (rsp_wire_word),
      .rsp_select_mask (rsp_select_mask),
      .rsp_frame_end   (rsp_frame_end),
      .rsp_run_last    (rsp_run_last)
   );

endmodule

`default_nettype wire

// ===== rtl/lmcr_ram.sv =====
`default_nettype none

module lmcr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // single write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/lmcr_front.sv =====
`default_nettype none

module lmcr_front (
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [2:0]                   req_type,
   input  wire logic [lmcr_pkg::FB_IDX_W-1:0] req_buffer_index,
   input  wire logic [3:0]                   req_reg_address,
   input  wire logic [7:0]                   req_value,
   input  wire logic                         q_full,
   output logic                              push,
   output lmcr_pkg::cmd_type                 push_cmd
);

   logic known;

   assign req_stall = q_full;

   // classify the request into a queued command
   always_comb begin
      known          = 1'b1;
      push_cmd.kind  = lmcr_pkg::KIND_WRITE;
      push_cmd.index = req_buffer_index;
      push_cmd.addr  = {4'b0000, req_reg_address};
      push_cmd.data  = req_value;
      unique case (req_type)
         lmcr_pkg::REQ_WRITE: begin
            push_cmd.kind = lmcr_pkg::KIND_WRITE;
         end
         lmcr_pkg::REQ_REFRESH: begin
            push_cmd.kind = lmcr_pkg::KIND_REFRESH;
         end
         lmcr_pkg::REQ_COMMAND: begin
            push_cmd.kind = lmcr_pkg::KIND_COMMAND;
         end
         lmcr_pkg::REQ_INTENSITY: begin
            // intensity is a command-all with a clamped value
            push_cmd.kind = lmcr_pkg::KIND_COMMAND;
            push_cmd.addr = lmcr_pkg::REG_INTENSITY;
            if (req_value > lmcr_pkg::INTENSITY_LIMIT) begin
               push_cmd.data = lmcr_pkg::INTENSITY_LIMIT;
            end
         end
         lmcr_pkg::REQ_CLEAR: begin
            push_cmd.kind = lmcr_pkg::KIND_CLEAR;
         end
         lmcr_pkg::REQ_INIT: begin
            push_cmd.kind = lmcr_pkg::KIND_INIT;
         end
         default: begin
            // unknown codes are taken and dropped
            known = 1'b0;
         end
      endcase
   end

   assign push = req_valid && !q_full && known;

endmodule

`default_nettype wire

// ===== rtl/lmcr_queue.sv =====
`default_nettype none

module lmcr_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire lmcr_pkg::cmd_type push_cmd,
   output logic                   full,
   input  wire logic              pop,
   output logic                   head_valid,
   output lmcr_pkg::cmd_type      head_cmd
);

   localparam int PTR_W = (lmcr_pkg::QUEUE_DEPTH > 1) ? $clog2(lmcr_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(lmcr_pkg::QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(lmcr_pkg::QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(lmcr_pkg::QUEUE_DEPTH);

   lmcr_pkg::cmd_type  entry_ff [lmcr_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full       = (count_ff == CNT_FULL);
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/lmcr_back.sv =====
`default_nettype none

module lmcr_back #(
   parameter int DRIVERS_PER_COMMAND = lmcr_pkg::DRIVERS_PER_COMMAND_DEF,
   parameter int ROWS                = lmcr_pkg::ROWS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              head_valid,
   input  wire lmcr_pkg::cmd_type head_cmd,
   output logic                   pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [15:0]            rsp_wire_word,
   output logic [1:0]             rsp_select_mask,
   output logic                   rsp_frame_end,
   output logic                   rsp_run_last
);

   localparam int IW = lmcr_pkg::FB_IDX_W;
   localparam logic [2:0] REP_LAST   = 3'(DRIVERS_PER_COMMAND - 1);
   localparam logic [2:0] CHAIN_LAST = 3'd7;
   localparam logic [3:0] ROW_LAST   = 4'(ROWS);
   localparam logic [5:0] CNT_LAST   = 6'd63;

   function automatic logic [7:0] reverse_byte(input logic [7:0] b);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[i] = b[7-i];
      end
      return r;
   endfunction

   // sequencer state
   lmcr_pkg::phase_type state_ff, state_in;
   logic [7:0]          cmd_addr_ff, cmd_addr_in;
   logic [7:0]          cmd_data_ff, cmd_data_in;
   logic [3:0]          row_ff, row_in;
   logic [2:0]          rep_ff, rep_in;
   logic [5:0]          cnt_ff, cnt_in;
   logic [lmcr_pkg::FB_DEPTH-1:0] fill_ff, fill_in;

   // word formed this cycle
   logic          emit;
   logic [7:0]    g_addr, g_data;
   logic          g_ram;
   logic [IW-1:0] g_idx;
   logic [1:0]    g_mask;
   logic          g_fe, g_nat_last, g_last;
   logic          rep_end;
   logic [IW-1:0] row_base;

   // read stage
   logic          s1_valid_ff, s1_valid_in;
   logic [7:0]    s1_addr_ff, s1_addr_in;
   logic [7:0]    s1_data_ff, s1_data_in;
   logic          s1_ram_ff, s1_ram_in;
   logic          s1_fill_ff, s1_fill_in;
   logic [IW-1:0] s1_idx_ff, s1_idx_in;
   logic [1:0]    s1_mask_ff, s1_mask_in;
   logic          s1_fe_ff, s1_fe_in;
   logic          s1_last_ff, s1_last_in;

   // output register
   logic          out_valid_ff, out_valid_in;
   logic [15:0]   out_word_ff, out_word_in;
   logic [1:0]    out_mask_ff, out_mask_in;
   logic          out_fe_ff, out_fe_in;
   logic          out_last_ff, out_last_in;

   logic          s1_move, gen_adv;
   logic          wr_en;
   logic [IW-1:0] rd_addr;
   logic [7:0]    rd_data;

   assign s1_move = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign gen_adv = !s1_valid_ff || s1_move;
   assign rd_addr = gen_adv ? g_idx : s1_idx_ff;

   lmcr_ram #(
      .WIDTH (8),
      .DEPTH (lmcr_pkg::FB_DEPTH)
   ) u_frame_buffer (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (head_cmd.index),
      .wr_data (head_cmd.data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // word content for the current phase
   always_comb begin
      rep_end    = (rep_ff == REP_LAST);
      row_base   = 6'd36 - {row_ff, 2'b00};
      g_addr     = cmd_addr_ff;
      g_data     = cmd_data_ff;
      g_ram      = 1'b0;
      g_idx      = row_base + 6'd31 - {4'b0000, rep_ff[1:0]};
      g_mask     = lmcr_pkg::SEL_BOTH;
      g_fe       = rep_end;
      g_nat_last = 1'b0;
      unique case (state_ff)
         lmcr_pkg::PH_IDLE: begin
         end
         lmcr_pkg::PH_DECODE: begin
            g_addr = lmcr_pkg::REG_DECODE;
            g_data = lmcr_pkg::DATA_ZERO;
         end
         lmcr_pkg::PH_INTENSITY: begin
            g_addr = lmcr_pkg::REG_INTENSITY;
            g_data = lmcr_pkg::DATA_ZERO;
         end
         lmcr_pkg::PH_SCAN: begin
            g_addr = lmcr_pkg::REG_SCAN_LIMIT;
            g_data = lmcr_pkg::DATA_SCAN_ALL;
         end
         lmcr_pkg::PH_SHUTDOWN: begin
            g_addr = lmcr_pkg::REG_SHUTDOWN;
            g_data = lmcr_pkg::DATA_NORMAL_OP;
         end
         lmcr_pkg::PH_TEST: begin
            g_addr = lmcr_pkg::REG_DISPLAY_TEST;
            g_data = lmcr_pkg::DATA_ZERO;
         end
         lmcr_pkg::PH_CLEAR: begin
            g_addr     = {4'b0000, row_ff};
            g_data     = lmcr_pkg::DATA_ZERO;
            g_nat_last = rep_end && (row_ff == ROW_LAST);
         end
         lmcr_pkg::PH_COMMAND: begin
            g_nat_last = rep_end;
         end
         lmcr_pkg::PH_REFRESH: begin
            // first half of the row from the upper bank, second from the lower
            g_addr = {4'b0000, row_ff};
            g_ram  = 1'b1;
            g_mask = lmcr_pkg::SEL_FIRST;
            g_fe   = (rep_ff == CHAIN_LAST);
            g_nat_last = g_fe && (row_ff == ROW_LAST);
            if (rep_ff[2]) begin
               g_idx = row_base - 6'd1 - {4'b0000, rep_ff[1:0]};
            end
         end
         default: begin
         end
      endcase
      emit   = gen_adv && (state_ff != lmcr_pkg::PH_IDLE);
      g_last = g_nat_last || (cnt_ff == CNT_LAST);
   end

   // sequencer next state
   always_comb begin
      state_in    = state_ff;
      cmd_addr_in = cmd_addr_ff;
      cmd_data_in = cmd_data_ff;
      row_in      = row_ff;
      rep_in      = rep_ff;
      cnt_in      = cnt_ff;
      fill_in     = fill_ff;
      pop         = 1'b0;
      wr_en       = 1'b0;
      if (state_ff == lmcr_pkg::PH_IDLE) begin
         if (head_valid && gen_adv) begin
            pop         = 1'b1;
            cmd_addr_in = head_cmd.addr;
            cmd_data_in = head_cmd.data;
            row_in      = 4'd1;
            rep_in      = '0;
            cnt_in      = '0;
            unique case (head_cmd.kind)
               lmcr_pkg::KIND_WRITE: begin
                  wr_en                   = 1'b1;
                  fill_in[head_cmd.index] = 1'b1;
               end
               lmcr_pkg::KIND_REFRESH: state_in = lmcr_pkg::PH_REFRESH;
               lmcr_pkg::KIND_COMMAND: state_in = lmcr_pkg::PH_COMMAND;
               lmcr_pkg::KIND_CLEAR:   state_in = lmcr_pkg::PH_CLEAR;
               lmcr_pkg::KIND_INIT:    state_in = lmcr_pkg::PH_DECODE;
               default: begin
               end
            endcase
         end
      end else if (emit) begin
         cnt_in = cnt_ff + 6'd1;
         rep_in = rep_ff + 3'd1;
         if (g_fe) begin
            rep_in = '0;
            unique case (state_ff)
               lmcr_pkg::PH_DECODE:    state_in = lmcr_pkg::PH_INTENSITY;
               lmcr_pkg::PH_INTENSITY: state_in = lmcr_pkg::PH_SCAN;
               lmcr_pkg::PH_SCAN:      state_in = lmcr_pkg::PH_SHUTDOWN;
               lmcr_pkg::PH_SHUTDOWN:  state_in = lmcr_pkg::PH_TEST;
               lmcr_pkg::PH_TEST:      state_in = lmcr_pkg::PH_CLEAR;
               default: begin
                  row_in = row_ff + 4'd1;
               end
            endcase
         end
         if (g_last) begin
            state_in = lmcr_pkg::PH_IDLE;
         end
      end
   end

   // read stage and output register
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_addr_in  = s1_addr_ff;
      s1_data_in  = s1_data_ff;
      s1_ram_in   = s1_ram_ff;
      s1_fill_in  = s1_fill_ff;
      s1_idx_in   = s1_idx_ff;
      s1_mask_in  = s1_mask_ff;
      s1_fe_in    = s1_fe_ff;
      s1_last_in  = s1_last_ff;
      if (gen_adv) begin
         s1_valid_in = emit;
         s1_addr_in  = g_addr;
         s1_data_in  = g_data;
         s1_ram_in   = g_ram;
         s1_fill_in  = fill_ff[g_idx];
         s1_idx_in   = g_idx;
         s1_mask_in  = g_mask;
         s1_fe_in    = g_fe;
         s1_last_in  = g_last;
      end

      out_valid_in = out_valid_ff;
      out_word_in  = out_word_ff;
      out_mask_in  = out_mask_ff;
      out_fe_in    = out_fe_ff;
      out_last_in  = out_last_ff;
      if (s1_move) begin
         out_valid_in = 1'b1;
         out_word_in[15:8] = s1_addr_ff;
         out_word_in[7:0]  = s1_data_ff;
         if (s1_ram_ff) begin
            // never-written bytes read as zero
            out_word_in[7:0] = s1_fill_ff ? reverse_byte(rd_data) : lmcr_pkg::DATA_ZERO;
         end
         out_mask_in = s1_mask_ff;
         out_fe_in   = s1_fe_ff;
         out_last_in = s1_last_ff;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lmcr_pkg::PH_IDLE;
         fill_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_addr_ff <= cmd_addr_in;
      cmd_data_ff <= cmd_data_in;
      row_ff      <= row_in;
      rep_ff      <= rep_in;
      cnt_ff      <= cnt_in;
      s1_addr_ff  <= s1_addr_in;
      s1_data_ff  <= s1_data_in;
      s1_ram_ff   <= s1_ram_in;
      s1_fill_ff  <= s1_fill_in;
      s1_idx_ff   <= s1_idx_in;
      s1_mask_ff  <= s1_mask_in;
      s1_fe_ff    <= s1_fe_in;
      s1_last_ff  <= s1_last_in;
      out_word_ff <= out_word_in;
      out_mask_ff <= out_mask_in;
      out_fe_ff   <= out_fe_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_wire_word   = out_word_ff;
   assign rsp_select_mask = out_mask_ff;
   assign rsp_frame_end   = out_fe_ff;
   assign rsp_run_last    = out_last_ff;

endmodule

`default_nettype wire
